[rtl/ppool_pkg.sv]
// Shared types and constants for the particle pool.
`default_nettype none
package ppool_pkg;
    localparam int PoolDepth = 32;
    localparam int IdW       = 5;
    localparam int CntW      = 6;
    localparam int FracBits  = 16;
    localparam int QuoW      = FracBits + 1;
    localparam int CfgAddrW  = 5;

    localparam logic [FracBits-1:0] AlphaOne = '1;

    localparam logic [2:0] RegGravity = 3'd0;
    localparam logic [2:0] RegOrigX   = 3'd1;
    localparam logic [2:0] RegOrigY   = 3'd2;
    localparam logic [2:0] RegOrigZ   = 3'd3;
    localparam logic [2:0] RegLimit   = 3'd4;

    localparam logic ReqTick  = 1'b0;
    localparam logic ReqSpawn = 1'b1;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] age;
        logic [31:0] limit;
    } slot_t;

    typedef struct packed {
        logic            start;
        logic [31:0]     dividend;
        logic [30:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [QuoW-1:0] quo;
    } div_rsp_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SPAWN = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_PUSH  = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

[rtl/ppool_div.sv]
// Restoring divider, one quotient bit per cycle, for the alpha ratio.
`default_nettype none
module ppool_div import ppool_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [32:0]     rem_reg;
    logic [QuoW-1:0] quo_reg;
    logic [30:0]     dsr_reg;
    logic [4:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [32:0]     diff;

    assign diff = rem_reg - {2'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !req.start && busy_reg && (cnt_reg == 5'(QuoW - 1));
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= {1'b0, req.dividend};
                dsr_reg  <= req.divisor;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                // Each step decides one quotient bit, most significant first.
                if (!diff[32]) begin
                    rem_reg <= {diff[31:0], 1'b0};
                    quo_reg <= {quo_reg[QuoW-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[31:0], 1'b0};
                    quo_reg <= {quo_reg[QuoW-2:0], 1'b0};
                end
                if (cnt_reg == 5'(QuoW - 1)) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
`default_nettype wire

[rtl/particle_pool_step.sv]
// Top level of the particle pool: slot memory, sequencer and ports.
//
// Usage: requests arrive on the s_ channel; tuser[0] selects a tick (0) or a
// spawn (1). A spawn answers with one result carrying the new id and the
// emitter origin, or a pool-full flag. A tick ages and moves every live
// particle and then lists the survivors in ascending id order; tlast marks
// the final result of each request, and a tick with no survivor gives one
// result with entry_valid low.
// Sequencing: a spawn goes from idle to the spawn state, which loads its
// result into the result register. A tick visits each live particle in the
// scan and load states; one that expires goes straight back to scan, a
// survivor with an immortal limit goes on to push, and a survivor with a
// positive limit first waits in the divide state for the bit-serial alpha
// divider (17 quotient steps). The finish state ends the tick and returns to
// idle. Gaps between live slots are skipped in one scan step. A request is
// accepted only while the sequencer is idle, one request at a time.
// All slot data sits in one 32-entry memory with a registered
// read; alive flags and the live count are flip-flops.
// Reset clears the alive flags, the live count, the registers (pool limit
// to 32) and both channels. When the receiver stalls the result register
// holds, and the sequencer waits before it loads the next result.
`default_nettype none
module particle_pool_step import ppool_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [30:0] delta_time, [62:31] start_vel_x, [94:63] start_vel_y,
    // [126:95] start_vel_z, [158:127] life_limit, [159] zero
    input  wire logic [159:0]        s_tdata,
    // [0] req_type
    input  wire logic [0:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [4:0] particle_id, [36:5] out_pos_x, [68:37] out_pos_y,
    // [100:69] out_pos_z, [116:101] out_alpha, [119:117] zero
    output logic [119:0]             m_tdata,
    // [0] from_spawn, [1] pool_full, [2] entry_valid
    output logic [2:0]               m_tuser,
    output logic                     m_tlast,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [CfgAddrW-1:0] paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    // Configuration registers.
    logic [31:0]     gravity_reg, orig_x_reg, orig_y_reg, orig_z_reg;
    logic [CntW-1:0] plimit_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= '0;
            orig_x_reg  <= '0;
            orig_y_reg  <= '0;
            orig_z_reg  <= '0;
            plimit_reg  <= CntW'(PoolDepth);
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                RegGravity: gravity_reg <= pwdata;
                RegOrigX:   orig_x_reg  <= pwdata;
                RegOrigY:   orig_y_reg  <= pwdata;
                RegOrigZ:   orig_z_reg  <= pwdata;
                RegLimit:   plimit_reg  <= pwdata[CntW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            RegGravity: prdata = gravity_reg;
            RegOrigX:   prdata = orig_x_reg;
            RegOrigY:   prdata = orig_y_reg;
            RegOrigZ:   prdata = orig_z_reg;
            RegLimit:   prdata = {26'b0, plimit_reg};
            default:    prdata = '0;
        endcase
    end

    // Sequencer state and captured request.
    state_t          state_reg;
    logic [30:0]     dt_reg;
    logic [31:0]     vx_reg, vy_reg, vz_reg, lim_in_reg;
    logic [PoolDepth-1:0] alive_reg;
    logic [CntW-1:0] live_reg;
    logic [CntW-1:0] scan_reg;      // next slot to examine; may equal the depth
    logic [IdW-1:0]  cur_id_reg;

    // Slot memory.
    slot_t           mem [PoolDepth];
    slot_t           rd_q;
    logic [IdW-1:0]  rd_addr;
    logic            mem_we;
    logic [IdW-1:0]  wr_addr;
    slot_t           wr_data;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    // Lowest alive slot at or above the scan point, and lowest free slot.
    logic [PoolDepth-1:0] scan_mask;
    logic            nxt_found, free_found;
    logic [IdW-1:0]  nxt_id, free_id;

    always_comb begin
        scan_mask  = '0;
        nxt_found  = 1'b0;
        nxt_id     = '0;
        free_found = 1'b0;
        free_id    = '0;
        for (int i = PoolDepth - 1; i >= 0; i--) begin
            scan_mask[i] = (CntW'(i) >= scan_reg);
            if (alive_reg[i] && scan_mask[i]) begin
                nxt_found = 1'b1;
                nxt_id    = IdW'(i);
            end
            if (!alive_reg[i]) begin
                free_found = 1'b1;
                free_id    = IdW'(i);
            end
        end
    end

    // Update of one slot during a tick.
    logic [32:0] age_sum;
    logic [31:0] age_new;
    logic        lim_pos, dies;
    slot_t       upd;

    assign age_sum = {1'b0, rd_q.age} + {2'b0, dt_reg};
    assign age_new = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    assign lim_pos = !rd_q.limit[31] && (rd_q.limit != '0);
    assign dies    = lim_pos && (age_new > rd_q.limit);

    always_comb begin
        upd       = rd_q;
        upd.age   = age_new;
        upd.pos_x = rd_q.pos_x + rd_q.vel_x;
        upd.pos_y = rd_q.pos_y + rd_q.vel_y;
        upd.pos_z = rd_q.pos_z + rd_q.vel_z;
        upd.vel_y = rd_q.vel_y - gravity_reg;
    end

    // Alpha divider.
    div_req_t div_req;
    div_rsp_t div_rsp;

    ppool_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic [FracBits-1:0] div_alpha;
    always_comb begin
        if (div_rsp.quo == '0)         div_alpha = AlphaOne;
        else if (div_rsp.quo[QuoW-1])  div_alpha = '0;
        else                           div_alpha = FracBits'(~div_rsp.quo + QuoW'(1));
    end

    // Current and held listing entries; the held one goes out once the
    // next survivor or the end of the scan tells whether it is the last.
    logic [31:0]         cur_px_reg, cur_py_reg, cur_pz_reg;
    logic [FracBits-1:0] cur_alpha_reg;
    logic                held_v_reg;
    logic [IdW-1:0]      held_id_reg;
    logic [31:0]         held_px_reg, held_py_reg, held_pz_reg;
    logic [FracBits-1:0] held_alpha_reg;

    // Result register.
    logic          out_free;
    logic          out_load;
    logic [119:0]  out_data_reg;
    logic [2:0]    out_user_reg;
    logic          out_last_reg;
    logic          out_v_reg;

    assign out_free = !out_v_reg || m_tready;
    // The sequencer fills the result register in these states once it is free.
    assign out_load = out_free && ((state_reg == S_SPAWN) || (state_reg == S_FIN)
                                   || (state_reg == S_PUSH && held_v_reg));
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;
    assign s_tready = (state_reg == S_IDLE);

    logic [CntW-1:0] cap;
    logic            spawn_ok;
    assign cap      = (plimit_reg > CntW'(PoolDepth)) ? CntW'(PoolDepth) : plimit_reg;
    assign spawn_ok = (live_reg < cap) && free_found;

    always_comb begin
        rd_addr          = nxt_id;
        mem_we           = 1'b0;
        wr_addr          = cur_id_reg;
        wr_data          = upd;
        div_req.start    = 1'b0;
        div_req.dividend = age_new;
        div_req.divisor  = rd_q.limit[30:0];
        if (state_reg == S_SPAWN && out_free && spawn_ok) begin
            mem_we        = 1'b1;
            wr_addr       = free_id;
            wr_data.pos_x = orig_x_reg;
            wr_data.pos_y = orig_y_reg;
            wr_data.pos_z = orig_z_reg;
            wr_data.vel_x = vx_reg;
            wr_data.vel_y = vy_reg;
            wr_data.vel_z = vz_reg;
            wr_data.age   = '0;
            wr_data.limit = lim_in_reg;
        end else if (state_reg == S_LOAD && !dies) begin
            mem_we        = 1'b1;
            div_req.start = lim_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            alive_reg  <= '0;
            live_reg   <= '0;
            scan_reg   <= '0;
            held_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            if (out_load) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        dt_reg        <= s_tdata[30:0];
                        vx_reg        <= s_tdata[62:31];
                        vy_reg        <= s_tdata[94:63];
                        vz_reg        <= s_tdata[126:95];
                        lim_in_reg    <= s_tdata[158:127];
                        scan_reg      <= '0;
                        state_reg     <= (s_tuser[0] == ReqSpawn) ? S_SPAWN : S_SCAN;
                    end
                end
                S_SPAWN: begin
                    if (out_free) begin
                        out_last_reg <= 1'b1;
                        if (spawn_ok) begin
                            alive_reg[free_id] <= 1'b1;
                            live_reg     <= live_reg + CntW'(1);
                            out_user_reg <= 3'b101;
                            out_data_reg <= {3'b0, AlphaOne, orig_z_reg, orig_y_reg,
                                             orig_x_reg, free_id};
                        end else begin
                            out_user_reg <= 3'b011;
                            out_data_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (nxt_found) begin
                        cur_id_reg <= nxt_id;
                        state_reg  <= S_LOAD;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_LOAD: begin
                    if (dies) begin
                        alive_reg[cur_id_reg] <= 1'b0;
                        if (live_reg != '0) live_reg <= live_reg - CntW'(1);
                        scan_reg  <= {1'b0, cur_id_reg} + CntW'(1);
                        state_reg <= S_SCAN;
                    end else begin
                        cur_px_reg    <= upd.pos_x;
                        cur_py_reg    <= upd.pos_y;
                        cur_pz_reg    <= upd.pos_z;
                        cur_alpha_reg <= AlphaOne;
                        state_reg     <= lim_pos ? S_DIV : S_PUSH;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        cur_alpha_reg <= div_alpha;
                        state_reg     <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!held_v_reg || out_free) begin
                        if (held_v_reg) begin
                            out_last_reg <= 1'b0;
                            out_user_reg <= 3'b100;
                            out_data_reg <= {3'b0, held_alpha_reg, held_pz_reg,
                                             held_py_reg, held_px_reg, held_id_reg};
                        end
                        held_v_reg     <= 1'b1;
                        held_id_reg    <= cur_id_reg;
                        held_px_reg    <= cur_px_reg;
                        held_py_reg    <= cur_py_reg;
                        held_pz_reg    <= cur_pz_reg;
                        held_alpha_reg <= cur_alpha_reg;
                        scan_reg       <= {1'b0, cur_id_reg} + CntW'(1);
                        state_reg      <= S_SCAN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        out_last_reg <= 1'b1;
                        if (held_v_reg) begin
                            out_user_reg <= 3'b100;
                            out_data_reg <= {3'b0, held_alpha_reg, held_pz_reg,
                                             held_py_reg, held_px_reg, held_id_reg};
                        end else begin
                            out_user_reg <= 3'b000;
                            out_data_reg <= '0;
                        end
                        held_v_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
